// ===== rtl/core/pfc_pkg.sv =====
// ----------------------------------------------------------------------------
// pfc_pkg
// Shared codes, polynomial constants and fixed widths of the pose pipeline.
// ----------------------------------------------------------------------------
package pfc_pkg;

    typedef enum logic [1:0] {
        OP_FORWARD  = 2'd0,
        OP_BACKWARD = 2'd1,
        OP_ESTIMATE = 2'd2,
        OP_UPDATE   = 2'd3
    } op_t;

    // ROT_FWD: rotate by minus angle, no offset
    // ROT_BWD: offset plus rotation by angle
    // ROT_SUB: offset minus rotation by angle
    typedef enum logic [1:0] {
        ROT_FWD = 2'd0,
        ROT_BWD = 2'd1,
        ROT_SUB = 2'd2
    } rot_mode_t;

    localparam int X_W          = 31;
    localparam int TRIG_W       = 16;
    localparam int TRIG_LANES   = 4;
    localparam int HORNER_CELLS = 4;

    localparam logic [14:0] Q14_ONE = 15'd16384;

    localparam logic [31:0] P_C1 = 32'd1686629713;
    localparam logic [31:0] P_C3 = 32'd693598669;
    localparam logic [31:0] P_C5 = 32'd85569306;
    localparam logic [31:0] P_C7 = 32'd5026996;
    localparam logic [31:0] P_C9 = 32'd172272;

    function automatic logic [31:0] horner_coef(input int idx);
        logic [31:0] c;
        case (idx)
            0:       c = P_C7;
            1:       c = P_C5;
            2:       c = P_C3;
            default: c = P_C1;
        endcase
        return c;
    endfunction

endpackage

// ===== rtl/core/pfc_trig_cell.sv =====
// ----------------------------------------------------------------------------
// pfc_trig_cell
// One Horner step of the quarter-wave sine polynomial on every lane.
// ----------------------------------------------------------------------------
module pfc_trig_cell
    import pfc_pkg::*;
#(
    parameter int          LANES = 4,
    parameter logic [31:0] COEF  = 32'd0
)
(
    input  logic                       clk,
    input  logic                       en,
    input  logic [LANES-1:0][X_W-1:0]  x_in,
    input  logic [LANES-1:0][X_W-1:0]  x2_in,
    input  logic [LANES-1:0][X_W-1:0]  p_in,
    output logic [LANES-1:0][X_W-1:0]  x_out,
    output logic [LANES-1:0][X_W-1:0]  x2_out,
    output logic [LANES-1:0][X_W-1:0]  p_out
);

    logic [LANES-1:0][2*X_W-1:0] prod;
    logic [LANES-1:0][X_W-1:0]   p_next;
    logic [LANES-1:0][X_W-1:0]   x_reg;
    logic [LANES-1:0][X_W-1:0]   x2_reg;
    logic [LANES-1:0][X_W-1:0]   p_reg;

    always_comb
    begin
        for (int l = 0; l < LANES; l++)
        begin
            prod[l]   = (2*X_W)'(x2_in[l]) * (2*X_W)'(p_in[l]);
            p_next[l] = X_W'(COEF - prod[l][2*X_W-1:30]);
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            x_reg  <= x_in;
            x2_reg <= x2_in;
            p_reg  <= p_next;
        end
    end

    assign x_out  = x_reg;
    assign x2_out = x2_reg;
    assign p_out  = p_reg;

endmodule

// ===== rtl/core/pfc_rotate.sv =====
// ----------------------------------------------------------------------------
// pfc_rotate
// Two-stage rotation: rounded Q14 products, then offset and signed sums.
// ----------------------------------------------------------------------------
module pfc_rotate
    import pfc_pkg::*;
#(
    parameter int VW = 33,
    parameter int OW = 36
)
(
    input  logic                     clk,
    input  logic                     en_mul,
    input  logic                     en_sum,
    input  rot_mode_t                mode,
    input  logic signed [OW-1:0]     off_x,
    input  logic signed [OW-1:0]     off_y,
    input  logic signed [VW-1:0]     vec_x,
    input  logic signed [VW-1:0]     vec_y,
    input  logic signed [TRIG_W-1:0] cos_q,
    input  logic signed [TRIG_W-1:0] sin_q,
    output logic signed [OW-1:0]     res_x,
    output logic signed [OW-1:0]     res_y
);

    localparam int PW = VW + 2;

    function automatic logic signed [PW-1:0] mulq(input logic signed [VW-1:0] v,
                                                  input logic signed [TRIG_W-1:0] t);
        logic          neg;
        logic [VW-1:0] mv;
        logic [14:0]   mt;
        logic [VW+14:0] prod;
        logic [VW:0]   mag;
        neg  = v[VW-1] ^ t[TRIG_W-1];
        mv   = v[VW-1] ? VW'(-v) : VW'(v);
        mt   = t[TRIG_W-1] ? 15'(-t) : t[14:0];
        prod = (VW+15)'(mv) * (VW+15)'(mt) + (VW+15)'(8192);
        mag  = prod[VW+14:14];
        return neg ? -$signed({1'b0, mag}) : $signed({1'b0, mag});
    endfunction

    rot_mode_t            mode_reg;
    logic signed [OW-1:0] offx_reg, offy_reg;
    logic signed [PW-1:0] pxc_reg, pys_reg, pyc_reg, pxs_reg;
    logic signed [OW-1:0] res_x_next, res_y_next;
    logic signed [OW-1:0] res_x_reg, res_y_reg;
    logic signed [OW-1:0] txc, tys, tyc, txs;

    always_ff @(posedge clk)
    begin
        if (en_mul)
        begin
            mode_reg <= mode;
            offx_reg <= off_x;
            offy_reg <= off_y;
            pxc_reg  <= mulq(vec_x, cos_q);
            pys_reg  <= mulq(vec_y, sin_q);
            pyc_reg  <= mulq(vec_y, cos_q);
            pxs_reg  <= mulq(vec_x, sin_q);
        end
    end

    always_comb
    begin
        txc = OW'(pxc_reg);
        tys = OW'(pys_reg);
        tyc = OW'(pyc_reg);
        txs = OW'(pxs_reg);
        case (mode_reg)
            ROT_FWD:
            begin
                res_x_next = txc + tys;
                res_y_next = tyc - txs;
            end
            ROT_SUB:
            begin
                res_x_next = offx_reg - txc + tys;
                res_y_next = offy_reg - tyc - txs;
            end
            default:
            begin
                res_x_next = offx_reg + txc - tys;
                res_y_next = offy_reg + tyc + txs;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (en_sum)
        begin
            res_x_reg <= res_x_next;
            res_y_reg <= res_y_next;
        end
    end

    assign res_x = res_x_reg;
    assign res_y = res_y_reg;

endmodule

// ===== rtl/core/pose_frame_correction.sv =====
// ----------------------------------------------------------------------------
// pose_frame_correction
// Forward, backward, estimate and update of 2D pose corrections.
// ----------------------------------------------------------------------------
// Throughput: one transfer per cycle while m_tready is high, through the 13-stage
// trig and rotation pipeline, each stage holding one item. Bubbles close up under
// output stall.
// Reset clears the stage valid bits only; the pipeline is empty after reset.
module pose_frame_correction
    import pfc_pkg::*;
#(
    parameter int ANGLE_BITS = 16,
    parameter int COORD_BITS = 32
)
(
    input  logic clk,
    input  logic rst_n,
    input  logic s_tvalid,
    output logic s_tready,
    // pose_a_x, pose_a_y, pose_a_heading, pose_b_x, pose_b_y, pose_b_heading,
    // delta_x, delta_y, delta_heading, zero pad
    input  logic [((6*COORD_BITS+3*ANGLE_BITS+7)/8)*8-1:0] s_tdata,
    // operation
    input  logic [1:0] s_tuser,
    output logic m_tvalid,
    input  logic m_tready,
    // result_x, result_y, result_heading, zero pad
    output logic [((2*COORD_BITS+ANGLE_BITS+7)/8)*8-1:0] m_tdata
);

    localparam int CB       = COORD_BITS;
    localparam int AB       = ANGLE_BITS;
    localparam int VW       = CB + 1;
    localparam int OW       = CB + 4;
    localparam int NST      = 13;
    localparam int OUT_BITS = 2*CB + AB;
    localparam int OUT_W    = ((OUT_BITS + 7) / 8) * 8;
    localparam logic [AB-1:0] QUARTER_ANG = {2'b01, {(AB-2){1'b0}}};
    localparam logic [AB-2:0] QUARTER_R   = {1'b1, {(AB-2){1'b0}}};
    localparam logic signed [OW-1:0] SAT_HI = {{(OW-CB+1){1'b0}}, {(CB-1){1'b1}}};
    localparam logic signed [OW-1:0] SAT_LO = ~SAT_HI;

    typedef logic [TRIG_LANES-1:0][X_W-1:0] lanes_t;

    function automatic logic [CB-1:0] sat_coord(input logic signed [OW-1:0] v);
        logic [CB-1:0] r;
        if (v > SAT_HI)
            r = {1'b0, {(CB-1){1'b1}}};
        else if (v < SAT_LO)
            r = {1'b1, {(CB-1){1'b0}}};
        else
            r = v[CB-1:0];
        return r;
    endfunction

    // handshake and valid chain
    logic [NST:0]   en;
    logic [NST-1:0] vld_reg;

    always_comb
    begin
        en[NST] = m_tready;
        for (int k = NST - 1; k >= 0; k--)
            en[k] = !vld_reg[k] || en[k+1];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= '0;
        else
        begin
            if (en[0])
                vld_reg[0] <= s_tvalid;
            for (int k = 1; k < NST; k++)
                if (en[k])
                    vld_reg[k] <= vld_reg[k-1];
        end
    end

    assign s_tready = en[0];
    assign m_tvalid = vld_reg[NST-1];

    // input fields
    logic signed [CB-1:0] ax, ay, bx, by, dx, dy;
    logic [AB-1:0]        ah, bh, dh;
    op_t                  op;

    assign ax = s_tdata[CB-1:0];
    assign ay = s_tdata[2*CB-1:CB];
    assign ah = s_tdata[2*CB+AB-1:2*CB];
    assign bx = s_tdata[3*CB+AB-1:2*CB+AB];
    assign by = s_tdata[4*CB+AB-1:3*CB+AB];
    assign bh = s_tdata[4*CB+2*AB-1:4*CB+AB];
    assign dx = s_tdata[5*CB+2*AB-1:4*CB+2*AB];
    assign dy = s_tdata[6*CB+2*AB-1:5*CB+2*AB];
    assign dh = s_tdata[6*CB+3*AB-1:6*CB+2*AB];
    assign op = op_t'(s_tuser);

    // stage 0: operand selection and trig lane angles
    logic [AB-1:0]             h1, h2, rh_next;
    logic [TRIG_LANES-1:0][AB-1:0] ang;
    logic [1:0]                quad;
    logic [AB-2:0]             rr;
    rot_mode_t                 rot1_next, rot2_next;
    logic signed [VW-1:0]      vx_next, vy_next, qx_next, qy_next;
    logic signed [OW-1:0]      ox_next, oy_next;
    lanes_t                    x0_next;
    logic [TRIG_LANES-1:0]     neg_next;

    always_comb
    begin
        h1 = bh;
        h2 = (op == OP_ESTIMATE) ? ah - bh : bh - dh;
        rh_next   = h2;
        rot1_next = ROT_BWD;
        rot2_next = ROT_SUB;
        vx_next   = VW'(ax);
        vy_next   = VW'(ay);
        ox_next   = OW'(bx);
        oy_next   = OW'(by);
        qx_next   = VW'(ax) + VW'(dx);
        qy_next   = VW'(ay) + VW'(dy);
        case (op)
            OP_FORWARD:
            begin
                rh_next   = ah - bh;
                rot1_next = ROT_FWD;
                rot2_next = ROT_BWD;
                vx_next   = VW'(ax) - VW'(bx);
                vy_next   = VW'(ay) - VW'(by);
                ox_next   = '0;
                oy_next   = '0;
                qx_next   = '0;
                qy_next   = '0;
            end
            OP_BACKWARD:
            begin
                rh_next   = ah + bh;
                rot2_next = ROT_BWD;
                qx_next   = '0;
                qy_next   = '0;
            end
            OP_ESTIMATE:
            begin
                vx_next = '0;
                vy_next = '0;
                ox_next = OW'(ax);
                oy_next = OW'(ay);
                qx_next = VW'(bx);
                qy_next = VW'(by);
            end
            default:
            begin
            end
        endcase

        // lanes: sin h1, cos h1, sin h2, cos h2
        ang[0] = h1;
        ang[1] = h1 + QUARTER_ANG;
        ang[2] = h2;
        ang[3] = h2 + QUARTER_ANG;
        for (int l = 0; l < TRIG_LANES; l++)
        begin
            quad        = ang[l][AB-1:AB-2];
            rr          = quad[0] ? QUARTER_R - {1'b0, ang[l][AB-3:0]}
                                  : {1'b0, ang[l][AB-3:0]};
            x0_next[l]  = {rr, {(32-AB){1'b0}}};
            neg_next[l] = quad[1];
        end
    end

    // sideband pipelines
    rot_mode_t             rot1_reg [0:7];
    logic signed [VW-1:0]  vx_reg   [0:7];
    logic signed [VW-1:0]  vy_reg   [0:7];
    logic signed [OW-1:0]  ox_reg   [0:7];
    logic signed [OW-1:0]  oy_reg   [0:7];
    logic [TRIG_LANES-1:0] neg_reg  [0:6];
    rot_mode_t             rot2_reg [0:9];
    logic signed [VW-1:0]  qx_reg   [0:9];
    logic signed [VW-1:0]  qy_reg   [0:9];
    logic [AB-1:0]         rh_reg   [0:12];
    lanes_t                x0_reg;

    always_ff @(posedge clk)
    begin
        if (en[0])
        begin
            rot1_reg[0] <= rot1_next;
            vx_reg[0]   <= vx_next;
            vy_reg[0]   <= vy_next;
            ox_reg[0]   <= ox_next;
            oy_reg[0]   <= oy_next;
            neg_reg[0]  <= neg_next;
            rot2_reg[0] <= rot2_next;
            qx_reg[0]   <= qx_next;
            qy_reg[0]   <= qy_next;
            rh_reg[0]   <= rh_next;
            x0_reg      <= x0_next;
        end
        for (int k = 1; k < 7; k++)
            if (en[k])
                neg_reg[k] <= neg_reg[k-1];
        for (int k = 1; k < 8; k++)
            if (en[k])
            begin
                rot1_reg[k] <= rot1_reg[k-1];
                vx_reg[k]   <= vx_reg[k-1];
                vy_reg[k]   <= vy_reg[k-1];
                ox_reg[k]   <= ox_reg[k-1];
                oy_reg[k]   <= oy_reg[k-1];
            end
        for (int k = 1; k < 10; k++)
            if (en[k])
            begin
                rot2_reg[k] <= rot2_reg[k-1];
                qx_reg[k]   <= qx_reg[k-1];
                qy_reg[k]   <= qy_reg[k-1];
            end
        for (int k = 1; k < 13; k++)
            if (en[k])
                rh_reg[k] <= rh_reg[k-1];
    end

    // stage 1: x squared
    lanes_t x1_reg, x2_reg, x2_next;
    logic [TRIG_LANES-1:0][2*X_W-1:0] sq;

    always_comb
    begin
        for (int l = 0; l < TRIG_LANES; l++)
        begin
            sq[l]      = (2*X_W)'(x0_reg[l]) * (2*X_W)'(x0_reg[l]);
            x2_next[l] = sq[l][2*X_W-2:30];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en[1])
        begin
            x1_reg <= x0_reg;
            x2_reg <= x2_next;
        end
    end

    // stages 2 to 5: Horner cells
    lanes_t cx  [0:HORNER_CELLS];
    lanes_t cx2 [0:HORNER_CELLS];
    lanes_t cp  [0:HORNER_CELLS];

    assign cx[0]  = x1_reg;
    assign cx2[0] = x2_reg;
    always_comb
    begin
        for (int l = 0; l < TRIG_LANES; l++)
            cp[0][l] = X_W'(P_C9);
    end

    for (genvar g = 0; g < HORNER_CELLS; g++)
    begin : g_cell
        pfc_trig_cell #(
            .LANES (TRIG_LANES),
            .COEF  (horner_coef(g))
        ) u_cell (
            .clk    (clk),
            .en     (en[2+g]),
            .x_in   (cx[g]),
            .x2_in  (cx2[g]),
            .p_in   (cp[g]),
            .x_out  (cx[g+1]),
            .x2_out (cx2[g+1]),
            .p_out  (cp[g+1])
        );
    end

    // stage 6: final multiply; stage 7: round to Q14, cap, sign
    logic [TRIG_LANES-1:0][2*X_W-1:0] sp;
    logic [TRIG_LANES-1:0][31:0]      s_next, s_reg;
    logic [TRIG_LANES-1:0][32:0]      rnd;
    logic [TRIG_LANES-1:0][14:0]      mag;
    logic [TRIG_LANES-1:0][TRIG_W-1:0] q_next, q_reg;

    always_comb
    begin
        for (int l = 0; l < TRIG_LANES; l++)
        begin
            sp[l]     = (2*X_W)'(cx[HORNER_CELLS][l]) * (2*X_W)'(cp[HORNER_CELLS][l]);
            s_next[l] = sp[l][2*X_W-1:30];
            rnd[l]    = 33'(s_reg[l]) + 33'(32768);
            mag[l]    = (rnd[l][32:16] > 17'(Q14_ONE)) ? Q14_ONE : rnd[l][30:16];
            q_next[l] = neg_reg[6][l] ? TRIG_W'(-$signed({1'b0, mag[l]}))
                                      : TRIG_W'($signed({1'b0, mag[l]}));
        end
    end

    always_ff @(posedge clk)
    begin
        if (en[6])
            s_reg <= s_next;
        if (en[7])
            q_reg <= q_next;
    end

    // second angle trig carried to stage 9
    logic signed [TRIG_W-1:0] c2_reg [8:9];
    logic signed [TRIG_W-1:0] s2_reg [8:9];

    always_ff @(posedge clk)
    begin
        if (en[8])
        begin
            c2_reg[8] <= q_reg[3];
            s2_reg[8] <= q_reg[2];
        end
        if (en[9])
        begin
            c2_reg[9] <= c2_reg[8];
            s2_reg[9] <= s2_reg[8];
        end
    end

    // stages 8, 9: first rotation; stages 10, 11: second rotation
    logic signed [OW-1:0] r1x, r1y, r2x, r2y;

    pfc_rotate #(
        .VW (VW),
        .OW (OW)
    ) u_rot1 (
        .clk    (clk),
        .en_mul (en[8]),
        .en_sum (en[9]),
        .mode   (rot1_reg[7]),
        .off_x  (ox_reg[7]),
        .off_y  (oy_reg[7]),
        .vec_x  (vx_reg[7]),
        .vec_y  (vy_reg[7]),
        .cos_q  (q_reg[1]),
        .sin_q  (q_reg[0]),
        .res_x  (r1x),
        .res_y  (r1y)
    );

    pfc_rotate #(
        .VW (VW),
        .OW (OW)
    ) u_rot2 (
        .clk    (clk),
        .en_mul (en[10]),
        .en_sum (en[11]),
        .mode   (rot2_reg[9]),
        .off_x  (r1x),
        .off_y  (r1y),
        .vec_x  (qx_reg[9]),
        .vec_y  (qy_reg[9]),
        .cos_q  (c2_reg[9]),
        .sin_q  (s2_reg[9]),
        .res_x  (r2x),
        .res_y  (r2y)
    );

    // stage 12: saturation and output register
    logic [CB-1:0] out_x_reg, out_y_reg;

    always_ff @(posedge clk)
    begin
        if (en[12])
        begin
            out_x_reg <= sat_coord(r2x);
            out_y_reg <= sat_coord(r2y);
        end
    end

    assign m_tdata = OUT_W'({rh_reg[12], out_y_reg, out_x_reg});

endmodule
